@@ sv/hcbp_pkg.sv @@
// Shared constants and types for the Huffman code bit packer.
`default_nettype none

package hcbp_pkg;

    localparam int MAX_CODE_LEN  = 32;
    localparam int SYMBOL_COUNT  = 256;
    localparam int CODE_CAP      = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam int GROUP_BITS    = 7;
    localparam int WORD_W        = 32;
    localparam int LEN_W         = 6;
    localparam int PEND_W        = GROUP_BITS - 1;           // pending bits between items
    localparam int ACC_W         = CODE_CAP + PEND_W;        // pending plus one code word
    localparam int MAX_BYTES     = ACC_W / GROUP_BITS;       // full groups per item
    localparam int BUF_W         = MAX_BYTES * GROUP_BITS;
    localparam int CNT_W         = 3;                        // holds 0..MAX_BYTES
    localparam int PCNT_W        = 3;                        // holds 0..PEND_W
    localparam int SYM_AW        = $clog2(SYMBOL_COUNT);

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] code;
    } t_entry;

    // Group of full 7-bit chunks, right-aligned, first chunk most significant.
    typedef struct packed {
        logic [BUF_W-1:0] bits;
        logic [CNT_W-1:0] cnt;
    } t_grp;

endpackage

`default_nettype wire

@@ sv/hcbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hcbp_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_we,
    input  wire [$clog2(P_DEPTH)-1:0]   i_waddr,
    input  wire [P_WIDTH-1:0]           i_wdata,
    input  wire                         i_re,
    input  wire [$clog2(P_DEPTH)-1:0]   i_raddr,
    output logic [P_WIDTH-1:0]          o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/hcbp_pack.sv @@
// Merge stage: joins pending bits with the looked-up code and splits off 7-bit groups.
`default_nettype none

module hcbp_pack
    import hcbp_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_load,    // encode or flush beat enters this stage
    input  wire          i_flush,
    input  t_entry       i_entry,   // table read data for an encode beat
    input  wire          i_free,    // emit buffer takes a group this cycle
    output logic         o_busy,
    output logic         o_push,
    output t_grp         o_grp
);

    logic              r_valid;
    logic              r_flush;
    logic [PEND_W-1:0] r_acc;
    logic [PCNT_W-1:0] r_pcnt;

    logic              n_valid;
    logic [PEND_W-1:0] n_acc;
    logic [PCNT_W-1:0] n_pcnt;

    logic [ACC_W-1:0]  v;
    logic [LEN_W-1:0]  tot;
    logic [CNT_W-1:0]  nb;
    logic [PCNT_W-1:0] rem;
    logic [ACC_W-1:0]  sh;
    logic [PEND_W:0]   keep;
    logic [PEND_W-1:0] enc_acc;
    t_grp              grp;
    logic              adv;

    always_comb begin
        v    = (ACC_W'(r_acc) << i_entry.len) | ACC_W'(i_entry.code);
        tot  = LEN_W'(r_pcnt) + i_entry.len;
        // tot / 7 for tot <= 38 via reciprocal 37/256
        nb   = CNT_W'((11'(tot) * 11'd37) >> 8);
        rem  = PCNT_W'(tot - LEN_W'(LEN_W'(nb) * LEN_W'(GROUP_BITS)));
        sh   = v >> rem;
        keep = ((PEND_W+1)'(1) << rem) - (PEND_W+1)'(1);
        enc_acc = v[PEND_W-1:0] & keep[PEND_W-1:0];

        if (r_flush) begin
            grp.bits = BUF_W'(GROUP_BITS'({1'b0, r_acc} << (PCNT_W'(GROUP_BITS) - r_pcnt)));
            grp.cnt  = (r_pcnt != '0) ? CNT_W'(1) : '0;
        end else begin
            grp.bits = sh[BUF_W-1:0];
            grp.cnt  = nb;
        end
    end

    assign adv    = r_valid && ((grp.cnt == '0) || i_free);
    assign o_busy = r_valid && !adv;
    assign o_push = adv && (grp.cnt != '0);
    assign o_grp  = grp;

    always_comb begin
        n_valid = r_valid;
        n_acc   = r_acc;
        n_pcnt  = r_pcnt;
        if (adv) begin
            n_valid = 1'b0;
            if (r_flush) begin
                n_acc  = '0;
                n_pcnt = '0;
            end else begin
                n_acc  = enc_acc;
                n_pcnt = rem;
            end
        end
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
            r_pcnt  <= '0;
        end else begin
            r_valid <= n_valid;
            r_acc   <= n_acc;
            r_pcnt  <= n_pcnt;
        end
        if (i_load) begin
            r_flush <= i_flush;
        end
    end

`ifndef ASSERT_OFF
    a_pcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= PCNT_W'(PEND_W))
        else $error("pending count above group size");

    a_acc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc >> r_pcnt) == '0)
        else $error("stray bits above pending count");

    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> r_valid && $stable(r_flush))
        else $error("stalled merge beat lost");
`endif

endmodule

`default_nettype wire

@@ sv/hcbp_emit.sv @@
// Output buffer: sends one packed byte per beat from a group of 7-bit chunks.
`default_nettype none

module hcbp_emit
    import hcbp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  t_grp        i_grp,
    output logic        o_free,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);

    logic [BUF_W-1:0] r_bits;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [GROUP_BITS-1:0] chunk;

    assign o_valid = (r_cnt != '0);
    assign o_last  = (r_cnt == CNT_W'(1));
    assign o_free  = (r_cnt == '0) || (o_last && !i_stall);

    always_comb begin
        chunk = '0;
        for (int k = 1; k <= MAX_BYTES; k++) begin
            if (r_cnt == CNT_W'(k)) begin
                chunk = r_bits[k*GROUP_BITS-1 -: GROUP_BITS];
            end
        end
        o_out_byte = {chunk, 1'b0};
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_push) begin
            n_cnt = i_grp.cnt;
        end else if (o_valid && !i_stall) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_bits <= i_grp.bits;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_BYTES))
        else $error("byte count above group limit");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt == '0) || (r_cnt == CNT_W'(1) && !i_stall))
        else $error("group pushed over unsent bytes");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("stalled output beat changed");
`endif

endmodule

`default_nettype wire

@@ sv/huffman_code_bit_packer.sv @@
// Top level of the table-driven Huffman encoder with 7-bit byte packing.
// Pipeline: an encode or flush beat is accepted and its table entry is read on the same edge;
// the merge stage then pushes its 7-bit groups into the output buffer, which offers the bytes.
// Throughput: one input beat per cycle while items yield no bytes; an item with bytes holds
// the single output port until all are sent, and a later one stalls the input behind it.
// Reset (synchronous, active low) empties the pending bits and both pipeline stages;
// the code table is not cleared and holds garbage until loaded.
`default_nettype none

module huffman_code_bit_packer
    import hcbp_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // input channel
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire [1:0]           i_mode,
    input  wire [7:0]           i_symbol,
    input  wire [WORD_W-1:0]    i_code_word,
    input  wire [LEN_W-1:0]     i_code_length,
    // output channel
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_last
);

    logic          accept;
    logic          in_range;
    logic          do_load;
    logic          do_encode;
    logic          do_flush;
    logic [LEN_W-1:0] len_sat;
    logic [WORD_W:0]  code_mask;
    t_entry        wr_entry;
    t_entry        rd_entry;
    logic          pack_busy;
    logic          push;
    logic          emit_free;
    t_grp          grp;

    // Input beat is taken whenever the merge stage is not holding a stalled beat.
    assign accept    = i_valid && !o_stall;
    assign o_stall   = pack_busy;
    assign in_range  = (9'(i_symbol) < 9'(SYMBOL_COUNT));
    assign do_load   = accept && (i_mode == MODE_LOAD) && in_range;
    assign do_encode = accept && (i_mode == MODE_ENCODE) && in_range;
    assign do_flush  = accept && (i_mode == MODE_FLUSH);

    // Loads saturate the length and drop code bits at or above it.
    always_comb begin
        len_sat   = (i_code_length > LEN_W'(CODE_CAP)) ? LEN_W'(CODE_CAP) : i_code_length;
        code_mask = ((WORD_W+1)'(1) << len_sat) - (WORD_W+1)'(1);
        wr_entry.len  = len_sat;
        wr_entry.code = i_code_word & code_mask[WORD_W-1:0];
    end

    // Code and length share one table word; the read happens on the accept edge.
    hcbp_ram #(
        .P_WIDTH ($bits(t_entry)),
        .P_DEPTH (SYMBOL_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_waddr (i_symbol[SYM_AW-1:0]),
        .i_wdata (wr_entry),
        .i_re    (do_encode),
        .i_raddr (i_symbol[SYM_AW-1:0]),
        .o_rdata (rd_entry)
    );

    // Merge stage: pending bits plus code word, split into full 7-bit groups.
    hcbp_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (do_encode || do_flush),
        .i_flush (do_flush),
        .i_entry (rd_entry),
        .i_free  (emit_free),
        .o_busy  (pack_busy),
        .o_push  (push),
        .o_grp   (grp)
    );

    // Output buffer: one byte per beat, last set on the final byte of the group.
    hcbp_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_grp      (grp),
        .o_free     (emit_free),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire
